@@ design/keystroke_timing_verifier_defines.svh @@
// Assertion macros for the keystroke timing verifier
`ifndef KEYSTROKE_TIMING_VERIFIER_DEFINES_SVH
`define KEYSTROKE_TIMING_VERIFIER_DEFINES_SVH

// same-cycle implication
`define KTV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("keystroke_timing_verifier: assertion failed");

// next-cycle implication
`define KTV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("keystroke_timing_verifier: assertion failed");

`endif

@@ design/ktv_pkg.sv @@
// Types, codes and constants of the keystroke timing verifier
package ktv_pkg;
    localparam int MAX_KEYS_DEF    = 20;
    localparam int MAX_SAMPLES_DEF = 16;
    localparam int TS_W            = 32;
    localparam int KC_W            = 5;
    localparam int TOL_W           = 16;
    localparam int STATUS_W        = 3;
    localparam int MATCH_W         = 5;

    localparam logic [KC_W-1:0]  KEY_COUNT_RST = 5'd8;
    localparam logic [TOL_W-1:0] TOLERANCE_RST = 16'd150;

    localparam logic CFG_KEY_COUNT = 1'b0;
    localparam logic CFG_TOLERANCE = 1'b1;

    localparam logic [STATUS_W-1:0] STS_STORED   = 3'd0;
    localparam logic [STATUS_W-1:0] STS_READY    = 3'd1;
    localparam logic [STATUS_W-1:0] STS_PASS     = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FAIL     = 3'd3;
    localparam logic [STATUS_W-1:0] STS_MISMATCH = 3'd4;
    localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd5;

    typedef enum logic [1:0] {
        OP_ENROLL  = 2'd0,
        OP_ATTEMPT = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_CLR,
        ST_CV,
        ST_SCAN,
        ST_DEC
    } t_state;

    typedef struct packed {
        logic [KC_W-1:0]  key_count;
        logic [TOL_W-1:0] tolerance;
    } t_cfg;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [MATCH_W-1:0]  matched;
    } t_res;
endpackage

@@ design/ktv_key_if.sv @@
// Key item channel
interface ktv_key_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] timestamp;
    logic        last_key;

    modport source (output valid, operation, timestamp, last_key, input ready);
    modport sink   (input valid, operation, timestamp, last_key, output ready);
endinterface

@@ design/ktv_res_if.sv @@
// Result channel
interface ktv_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [4:0] matched_count;

    modport source (output valid, status, matched_count, input ready);
    modport sink   (input valid, status, matched_count, output ready);
endinterface

@@ design/ktv_ram.sv @@
// Generic single-port-write, registered-read RAM
module ktv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/ktv_core.sv @@
// Key processing, row clear sweep and median template sequencer
module ktv_core import ktv_pkg::*; #(
    parameter int MAX_KEYS    = MAX_KEYS_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_operation,
    input  logic [TS_W-1:0] i_timestamp,
    input  logic            i_last_key,
    input  logic            i_out_free,
    input  t_cfg            i_cfg,
    output logic            o_ready,
    output t_res            o_res
);
    localparam int AW  = $clog2(MAX_KEYS * MAX_SAMPLES);
    localparam int TAW = $clog2(MAX_KEYS);
    localparam int KPW = $clog2(MAX_KEYS + 2);
    localparam int RW  = $clog2(MAX_SAMPLES + 1);
    localparam int WW  = $clog2(MAX_KEYS);
    localparam int CW  = (KPW > KC_W) ? KPW : KC_W;

    t_state          r_state, n_state;
    logic [TS_W-1:0] r_prev, r_gap, r_v;
    logic [KPW-1:0]  r_kp, r_col;
    logic [WW-1:0]   r_wc;
    logic [RW-1:0]   r_stored, r_i, r_j, r_less, r_same;
    logic            r_tv, r_last, r_chk;
    t_op             r_op;

    logic            accept, kp_lt, full, in_tol, match, clr_needed, hit, last_i;
    logic            scan_more, col_last, enroll_ok;
    logic [TS_W-1:0] gap, tmpl, diff, st_rdata, st_wdata;
    logic [KPW-1:0]  kp_next, kc_col;
    logic [CW-1:0]   kc_ext, wc_ext;
    logic [WW-1:0]   wc_new;
    logic [RW-1:0]   k;
    logic [RW:0]     less_sum;
    logic            st_we, tp_we;
    logic [AW-1:0]   st_waddr, st_raddr;

    function automatic logic [AW-1:0] f_addr(input logic [RW-1:0] row,
                                             input logic [KPW-1:0] col);
        f_addr = AW'(row) * AW'(MAX_KEYS) + AW'(col);
    endfunction

    ktv_ram #(.WIDTH(TS_W), .DEPTH(MAX_KEYS * MAX_SAMPLES)) u_store (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    ktv_ram #(.WIDTH(TS_W), .DEPTH(MAX_KEYS)) u_tmpl (
        .i_clk  (i_clk),
        .i_we   (tp_we),
        .i_waddr(r_col[TAW-1:0]),
        .i_wdata(r_v),
        .i_raddr(r_kp[TAW-1:0]),
        .o_rdata(tmpl)
    );

    assign accept     = i_valid && o_ready;
    assign gap        = (r_kp == '0) ? '0 : i_timestamp - r_prev;
    assign kp_lt      = r_kp < KPW'(MAX_KEYS);
    assign full       = r_stored >= RW'(MAX_SAMPLES);
    assign kp_next    = (r_kp <= KPW'(MAX_KEYS)) ? r_kp + KPW'(1) : r_kp;
    assign diff       = (r_gap > tmpl) ? r_gap - tmpl : tmpl - r_gap;
    assign in_tol     = r_chk && (diff < TS_W'(i_cfg.tolerance));
    assign wc_new     = r_wc + WW'(in_tol);
    assign kc_ext     = CW'(i_cfg.key_count);
    assign wc_ext     = CW'(wc_new);
    assign kc_col     = kc_ext[KPW-1:0];
    assign match      = (CW'(r_kp) == kc_ext) && (kc_ext <= CW'(MAX_KEYS));
    assign clr_needed = kc_ext < CW'(MAX_KEYS);
    assign enroll_ok  = match && !full;
    assign k          = r_stored >> 1;
    assign less_sum   = (RW+1)'(r_less) + (RW+1)'(r_same);
    assign hit        = (r_less <= k) && ((RW+1)'(k) < less_sum);
    assign last_i     = r_i == r_stored - RW'(1);
    assign scan_more  = r_j < r_stored;
    assign col_last   = r_col == KPW'(MAX_KEYS - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_op'(i_operation)) inside
                        OP_ENROLL, OP_ATTEMPT: n_state = ST_KEY;
                        OP_COMPUTE: n_state = (r_stored != '0) ? ST_CV : ST_IDLE;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_KEY: begin
                n_state = (r_last && r_op == OP_ENROLL && enroll_ok && clr_needed)
                          ? ST_CLR : ST_IDLE;
            end
            ST_CLR:  n_state = col_last ? ST_IDLE : ST_CLR;
            ST_CV:   n_state = ST_SCAN;
            ST_SCAN: n_state = scan_more ? ST_SCAN : ST_DEC;
            ST_DEC:  n_state = ((hit || last_i) && col_last) ? ST_IDLE : ST_CV;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        st_we    = 1'b0;
        st_waddr = f_addr(r_stored, r_kp);
        st_wdata = gap;
        st_raddr = '0;
        tp_we    = 1'b0;
        o_res    = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = i_out_free;
                if (accept) begin
                    case (t_op'(i_operation)) inside
                        OP_ENROLL, OP_ATTEMPT: st_we = kp_lt && !full;
                        OP_COMPUTE: begin
                            if (r_stored == '0) begin
                                o_res.valid  = 1'b1;
                                o_res.status = STS_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_KEY: begin
                if (r_last) begin
                    o_res.valid = 1'b1;
                    if (!match) begin
                        o_res.status = STS_MISMATCH;
                    end else if (r_op == OP_ENROLL) begin
                        if (full) begin
                            o_res.status = STS_EMPTY;
                        end else begin
                            o_res.status = STS_STORED;
                            o_res.valid  = !clr_needed;
                        end
                    end else if (!r_tv) begin
                        o_res.status = STS_EMPTY;
                    end else begin
                        o_res.matched = wc_ext[MATCH_W-1:0];
                        o_res.status  = (wc_ext == kc_ext - CW'(1)) ? STS_PASS : STS_FAIL;
                    end
                end
            end
            ST_CLR: begin
                st_we    = 1'b1;
                st_waddr = f_addr(r_stored, r_col);
                st_wdata = '0;
                if (col_last) begin
                    o_res.valid  = 1'b1;
                    o_res.status = STS_STORED;
                end
            end
            ST_CV:   st_raddr = f_addr('0, r_col);
            ST_SCAN: st_raddr = f_addr(r_j, r_col);
            ST_DEC: begin
                if (hit || last_i) begin
                    tp_we = 1'b1;
                    if (col_last) begin
                        o_res.valid  = 1'b1;
                        o_res.status = STS_READY;
                    end else begin
                        st_raddr = f_addr('0, r_col + KPW'(1));
                    end
                end else begin
                    st_raddr = f_addr(r_i + RW'(1), r_col);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_prev   <= '0;
            r_kp     <= '0;
            r_wc     <= '0;
            r_stored <= '0;
            r_tv     <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (t_op'(i_operation)) inside
                            OP_ENROLL, OP_ATTEMPT: begin
                                r_gap  <= gap;
                                r_prev <= i_timestamp;
                                r_op   <= t_op'(i_operation);
                                r_last <= i_last_key;
                                r_chk  <= (r_kp != '0) && kp_lt && r_tv;
                                r_kp   <= kp_next;
                            end
                            OP_COMPUTE: begin
                                r_kp  <= '0;
                                r_wc  <= '0;
                                r_col <= '0;
                                r_i   <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_KEY: begin
                    if (!r_last) begin
                        r_wc <= wc_new;
                    end else begin
                        r_kp <= '0;
                        r_wc <= '0;
                        if (r_op == OP_ENROLL && enroll_ok) begin
                            if (clr_needed) begin
                                r_col <= kc_col;
                            end else begin
                                r_stored <= r_stored + RW'(1);
                            end
                        end
                    end
                end
                ST_CLR: begin
                    r_col <= r_col + KPW'(1);
                    if (col_last) begin
                        r_stored <= r_stored + RW'(1);
                    end
                end
                ST_CV: begin
                    r_v    <= st_rdata;
                    r_j    <= RW'(1);
                    r_less <= '0;
                    r_same <= '0;
                end
                ST_SCAN: begin
                    r_less <= r_less + RW'(st_rdata < r_v);
                    r_same <= r_same + RW'(st_rdata == r_v);
                    if (scan_more) begin
                        r_j <= r_j + RW'(1);
                    end
                end
                ST_DEC: begin
                    if (hit || last_i) begin
                        if (col_last) begin
                            r_tv <= 1'b1;
                        end else begin
                            r_col <= r_col + KPW'(1);
                            r_i   <= '0;
                        end
                    end else begin
                        r_i <= r_i + RW'(1);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

@@ design/keystroke_timing_verifier.sv @@
// Key item: taken in ST_IDLE while the output register is free; result formed in ST_KEY,
// then registered. Final enrollment key with key_count below MAX_KEYS: unused columns of
// the row cleared in ST_CLR first. Compute: for each of MAX_KEYS columns, each candidate
// row (N rows stored) passes ST_CV, ST_SCAN and ST_DEC, using the store RAM read port.
// Reset (synchronous, active low) empties the store count, drops the template and
// restores key_count 8 and tolerance 150.
module keystroke_timing_verifier import ktv_pkg::*; #(
    parameter int MAX_KEYS    = MAX_KEYS_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [TOL_W-1:0] i_cfg_wdata,
    ktv_key_if.sink          i_key,
    ktv_res_if.source        o_res
);
    t_cfg                r_cfg;
    t_res                core_res;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [MATCH_W-1:0]  r_matched;
    logic                out_free;

    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_count <= KEY_COUNT_RST;
            r_cfg.tolerance <= TOLERANCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_COUNT: r_cfg.key_count <= i_cfg_wdata[KC_W-1:0];
                CFG_TOLERANCE: r_cfg.tolerance <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    ktv_core #(.MAX_KEYS(MAX_KEYS), .MAX_SAMPLES(MAX_SAMPLES)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_key.valid),
        .i_operation(i_key.operation),
        .i_timestamp(i_key.timestamp),
        .i_last_key (i_key.last_key),
        .i_out_free (out_free),
        .i_cfg      (r_cfg),
        .o_ready    (i_key.ready),
        .o_res      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (core_res.valid) begin
            r_status  <= core_res.status;
            r_matched <= core_res.matched;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_status;
    assign o_res.matched_count = r_matched;
endmodule

@@ design/ktv_checker.sv @@
// Port-level checks of the keystroke timing verifier, bound to the top level
`include "keystroke_timing_verifier_defines.svh"

module ktv_checker import ktv_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_key_valid,
    input logic                i_key_ready,
    input logic [1:0]          i_key_op,
    input logic                i_res_valid,
    input logic                i_res_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [MATCH_W-1:0]  i_matched
);
    `KTV_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_status) && $stable(i_matched))
    `KTV_ASSERT_IMP(a_status_range, i_clk, i_rst_n, i_res_valid, i_status <= STS_EMPTY)
    `KTV_ASSERT_IMP(a_matched_zero, i_clk, i_rst_n, i_res_valid && i_status != STS_PASS && i_status != STS_FAIL, i_matched == '0)
    `KTV_ASSERT_NXT(a_none_silent, i_clk, i_rst_n, i_key_valid && i_key_ready && i_key_op == OP_NONE, !$rose(i_res_valid))
endmodule

bind keystroke_timing_verifier ktv_checker u_ktv_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_key_valid(i_key.valid),
    .i_key_ready(i_key.ready),
    .i_key_op   (i_key.operation),
    .i_res_valid(o_res.valid),
    .i_res_ready(o_res.ready),
    .i_status   (o_res.status),
    .i_matched  (o_res.matched_count)
);

@@ tb/tb_keystroke_timing_verifier.sv @@
// Self-checking testbench of the keystroke timing verifier: directed and random key streams
module tb_keystroke_timing_verifier;
    import ktv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NK        = MAX_KEYS_DEF;
    localparam int NS        = MAX_SAMPLES_DEF;
    localparam int CYC_LIMIT = 2_000_000;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [MATCH_W-1:0]  matched;
    } t_verdict;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [TOL_W-1:0] i_cfg_wdata;

    ktv_key_if key_ch ();
    ktv_res_if res_ch ();

    keystroke_timing_verifier u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_key       (key_ch),
        .o_res       (res_ch)
    );

    // shadow state
    logic [31:0]      gap_rows [NS*NK];
    logic [31:0]      tmpl_gaps [NK];
    logic [31:0]      last_ts;
    int               key_pos;
    int               rows_kept;
    int               hits;
    bit               tmpl_ok;
    logic [KC_W-1:0]  keys_cfg;
    logic [TOL_W-1:0] tol_cfg;

    t_verdict         verdict_q[$];
    int               errors;
    int               cycles;
    int               keys_sent;
    bit               quiet;
    bit               hold_req;
    int               stall_left;
    logic [31:0]      rhythm [NK];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit near(logic [31:0] gap, logic [31:0] tmpl);
        logic [31:0] d;
        d = (gap > tmpl) ? gap - tmpl : tmpl - gap;
        return d < {16'd0, tol_cfg};
    endfunction

    function automatic void build_template();
        logic [31:0] col[$];
        for (int c = 0; c < NK; c++) begin
            col.delete();
            for (int r = 0; r < rows_kept; r++) col.push_back(gap_rows[r*NK + c]);
            col.sort();
            tmpl_gaps[c] = col[rows_kept / 2];
        end
    endfunction

    function automatic void judge_key(t_op op, logic [31:0] ts, logic last);
        t_verdict    v;
        logic [31:0] gap;
        bit          fits;
        if (op == OP_NONE) return;
        v.matched = '0;
        if (op == OP_COMPUTE) begin
            key_pos = 0;
            hits    = 0;
            if (rows_kept == 0) begin
                v.status = STS_EMPTY;
            end else begin
                build_template();
                tmpl_ok  = 1'b1;
                v.status = STS_READY;
            end
            verdict_q.push_back(v);
            return;
        end
        gap     = (key_pos == 0) ? 32'd0 : ts - last_ts;
        last_ts = ts;
        if (key_pos < NK) begin
            if (rows_kept < NS) gap_rows[rows_kept*NK + key_pos] = gap;
            if (key_pos >= 1 && tmpl_ok && near(gap, tmpl_gaps[key_pos])) hits++;
        end
        if (key_pos <= NK) key_pos++;
        if (!last) return;
        fits = (key_pos == int'(keys_cfg)) && (int'(keys_cfg) <= NK);
        if (!fits) begin
            v.status = STS_MISMATCH;
        end else if (op == OP_ENROLL) begin
            if (rows_kept >= NS) begin
                v.status = STS_EMPTY;
            end else begin
                for (int c = int'(keys_cfg); c < NK; c++) gap_rows[rows_kept*NK + c] = '0;
                rows_kept++;
                v.status = STS_STORED;
            end
        end else if (!tmpl_ok) begin
            v.status = STS_EMPTY;
        end else begin
            v.matched = MATCH_W'(hits);
            v.status  = (hits == int'(keys_cfg) - 1) ? STS_PASS : STS_FAIL;
        end
        key_pos = 0;
        hits    = 0;
        verdict_q.push_back(v);
    endfunction

    task automatic send_key(t_op op, logic [31:0] ts, logic last);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            key_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        key_ch.valid     <= 1'b1;
        key_ch.operation <= op;
        key_ch.timestamp <= ts;
        key_ch.last_key  <= last;
        do @(posedge i_clk); while (!key_ch.ready);
        judge_key(op, ts, last);
        if (op != OP_NONE) keys_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        key_ch.valid <= 1'b0;
        wait (verdict_q.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [TOL_W-1:0] val);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_KEY_COUNT) keys_cfg = val[KC_W-1:0];
        else                      tol_cfg  = val;
    endtask

    task automatic type_seq(t_op op, int n, int jitter);
        logic [31:0] ts;
        ts = $urandom;
        for (int i = 0; i < n; i++) begin
            if (i > 0) ts = ts + rhythm[i % NK] + $urandom_range(0, 2*jitter) - jitter;
            send_key(op, ts, i == n - 1);
        end
    endtask

    task automatic new_rhythm();
        for (int i = 0; i < NK; i++) rhythm[i] = $urandom_range(50, 2000);
    endtask

    task automatic test_directed();
        write_reg(CFG_KEY_COUNT, 16'd3);
        send_key(OP_COMPUTE, 32'd0, 1'b0);
        send_key(OP_ATTEMPT, 32'd10, 1'b0);
        send_key(OP_ATTEMPT, 32'd20, 1'b0);
        send_key(OP_ATTEMPT, 32'd30, 1'b1);
        send_key(OP_NONE, 32'hFFFF_FFFF, 1'b1);
        send_key(OP_ENROLL, 32'd5, 1'b0);
        send_key(OP_ENROLL, 32'd9, 1'b1);
        send_key(OP_ENROLL, 32'd0, 1'b0);
        send_key(OP_ENROLL, 32'hFFFF_FFFF, 1'b0);
        send_key(OP_ENROLL, 32'd400, 1'b1);
        send_key(OP_ENROLL, 32'd77, 1'b0);
        send_key(OP_COMPUTE, 32'd0, 1'b1);
        send_key(OP_ATTEMPT, 32'h8000_0000, 1'b0);
        send_key(OP_ATTEMPT, 32'h7FFF_FFFF, 1'b0);
        send_key(OP_ATTEMPT, 32'h8000_0190, 1'b1);
        send_key(OP_ATTEMPT, 32'd100, 1'b0);
        send_key(OP_ATTEMPT, 32'd5000, 1'b0);
        send_key(OP_ATTEMPT, 32'd5001, 1'b1);
        // enroll and attempt keys mixed in one sequence
        send_key(OP_ENROLL, 32'd1000, 1'b0);
        send_key(OP_ENROLL, 32'd999, 1'b0);
        send_key(OP_ATTEMPT, 32'd1400, 1'b1);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_KEY_COUNT, 16'd1);
        write_reg(CFG_TOLERANCE, 16'd0);
        send_key(OP_ATTEMPT, $urandom, 1'b1);
        send_key(OP_ENROLL, $urandom, 1'b1);
        send_key(OP_ATTEMPT, $urandom, 1'b0);
        send_key(OP_ATTEMPT, $urandom, 1'b1);
        write_reg(CFG_KEY_COUNT, 16'd0);
        send_key(OP_ENROLL, $urandom, 1'b1);
        write_reg(CFG_KEY_COUNT, 16'd31);
        type_seq(OP_ENROLL, 21, 0);
        write_reg(CFG_KEY_COUNT, 16'hFFFF);
        write_reg(CFG_KEY_COUNT, 16'd20);
        write_reg(CFG_TOLERANCE, 16'hFFFF);
        new_rhythm();
        type_seq(OP_ENROLL, 20, 30);
        send_key(OP_COMPUTE, $urandom, 1'b0);
        type_seq(OP_ATTEMPT, 20, 30);
        type_seq(OP_ATTEMPT, 23, 0);
        type_seq(OP_ENROLL, 25, 0);
    endtask

    task automatic test_backpressure();
        write_reg(CFG_KEY_COUNT, 16'd2);
        write_reg(CFG_TOLERANCE, 16'd150);
        hold_req = 1'b1;
        for (int i = 0; i < 15; i++) type_seq(OP_ATTEMPT, 2, 100);
    endtask

    task automatic test_random(int target);
        int op_pick;
        int kc;
        int phase;
        phase = 0;
        while (keys_sent < target) begin
            if (phase % 200 == 0) begin
                kc = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 5);
                write_reg(CFG_KEY_COUNT, 16'(kc));
                case ($urandom_range(0, 3))
                    0:       write_reg(CFG_TOLERANCE, 16'd0);
                    1:       write_reg(CFG_TOLERANCE, 16'hFFFF);
                    default: write_reg(CFG_TOLERANCE, 16'($urandom_range(1, 600)));
                endcase
                new_rhythm();
                if (keys_sent > target * 3 / 4) quiet = 1'b1;
            end
            op_pick = $urandom_range(0, 99);
            if (op_pick < 40) begin
                type_seq(OP_ATTEMPT, kc, $urandom_range(0, 1) ? int'(tol_cfg) / 3 : 400);
            end else if (op_pick < 60) begin
                type_seq(OP_ENROLL, kc, 80);
            end else if (op_pick < 62) begin
                send_key(OP_COMPUTE, $urandom, 1'($urandom));
            end else if (op_pick < 72) begin
                type_seq(t_op'($urandom_range(0, 1)), $urandom_range(1, 23), 500);
            end else begin
                send_key(t_op'($urandom_range(0, 3)), $urandom, $urandom_range(0, 3) == 0);
            end
            phase = keys_sent;
            phase = phase - phase % 200 + ((phase % 200 < 12) ? 0 : 1);
        end
    endtask

    task automatic test_store_full();
        write_reg(CFG_KEY_COUNT, 16'd2);
        for (int i = 0; i < NS + 2; i++) type_seq(OP_ENROLL, 2, 50);
        send_key(OP_COMPUTE, $urandom, 1'b1);
        type_seq(OP_ATTEMPT, 2, 20);
    endtask

    // result sink with random and long stalls
    initial begin
        res_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = 400;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 11);
            end
            res_ch.ready <= (stall_left == 0) && i_rst_n;
            if (stall_left > 0) stall_left--;
        end
    end

    initial begin
        errors = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected beat: status %0d", res_ch.status);
                    errors++;
                end else begin
                    t_verdict v;
                    v = verdict_q.pop_front();
                    if (res_ch.status !== v.status) begin
                        $error("status: expected %0d, got %0d", v.status, res_ch.status);
                        errors++;
                    end
                    if (res_ch.matched_count !== v.matched) begin
                        $error("matched_count: expected %0d, got %0d",
                               v.matched, res_ch.matched_count);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYC_LIMIT) begin
                $display("[keystroke_timing_verifier] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_KEY_COUNT;
        i_cfg_wdata      = '0;
        key_ch.valid     = 1'b0;
        key_ch.operation = OP_NONE;
        key_ch.timestamp = '0;
        key_ch.last_key  = 1'b0;
        quiet            = 1'b0;
        hold_req         = 1'b0;
        keys_sent        = 0;
        last_ts          = '0;
        key_pos          = 0;
        rows_kept        = 0;
        hits             = 0;
        tmpl_ok          = 1'b0;
        keys_cfg         = KEY_COUNT_RST;
        tol_cfg          = TOLERANCE_RST;
        new_rhythm();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        test_backpressure();
        quiet = 1'b0;
        test_random(1250);
        test_store_full();
        settle();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && verdict_q.size() == 0)
            $display("[keystroke_timing_verifier] OK");
        else
            $display("[keystroke_timing_verifier] ERROR");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+design
design/ktv_pkg.sv
design/ktv_key_if.sv
design/ktv_res_if.sv
design/ktv_ram.sv
design/ktv_core.sv
design/keystroke_timing_verifier.sv
design/ktv_checker.sv
tb/tb_keystroke_timing_verifier.sv
